@@ rtl/tkfv_pkg.sv @@
// Shared types and constants for the top-k frequent value table.
// Holds the item structs, the result action codes and the controller command codes.
// Depends on nothing; every other file refers to it by scoped names.
package tkfv_pkg;

	localparam int SLOTS   = 16;
	localparam int KEY_W   = 64;
	localparam int COUNT_W = 48;
	localparam int CFG_W   = 5;
	localparam int ACT_W   = 3;
	localparam int SLOT_OUT_W = 4;

	// Slot index width and the width that can hold the fill count itself.
	localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int FILL_W = $clog2(SLOTS + 1);

	localparam logic [CFG_W-1:0] LIMIT_RESET = CFG_W'(16);

	// Result actions.
	localparam logic [ACT_W-1:0] ACT_UPDATED      = 3'd0;
	localparam logic [ACT_W-1:0] ACT_INSERTED     = 3'd1;
	localparam logic [ACT_W-1:0] ACT_REPLACED     = 3'd2;
	localparam logic [ACT_W-1:0] ACT_IGNORED      = 3'd3;
	localparam logic [ACT_W-1:0] ACT_REPORT_ENTRY = 3'd4;
	localparam logic [ACT_W-1:0] ACT_REPORT_EMPTY = 3'd5;

	// Request types.
	localparam logic REQ_OBSERVE = 1'b0;
	localparam logic REQ_REPORT  = 1'b1;

	// Datapath operations issued by the controller.
	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] OP_NONE   = 3'd0;
	localparam logic [OP_W-1:0] OP_LOAD   = 3'd1;
	localparam logic [OP_W-1:0] OP_SCAN   = 3'd2;
	localparam logic [OP_W-1:0] OP_COMMIT = 3'd3;
	localparam logic [OP_W-1:0] OP_RANK   = 3'd4;
	localparam logic [OP_W-1:0] OP_EMIT   = 3'd5;
	localparam logic [OP_W-1:0] OP_EMPTY  = 3'd6;

	typedef struct packed {
		logic               req_type;
		logic [KEY_W-1:0]   value_key;
		logic [COUNT_W-1:0] est_count;
	} req_t;

	typedef struct packed {
		logic [ACT_W-1:0]      action;
		logic [SLOT_OUT_W-1:0] slot_index;
		logic [KEY_W-1:0]      out_key;
		logic [COUNT_W-1:0]    out_count;
		logic                  last;
	} res_t;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [IDX_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic filled_zero;
		logic at_last;
	} status_t;

endpackage

@@ rtl/tkfv_ctrl.sv @@
// Controller state machine of the top-k frequent value table.
// Sequences the slot scan and commit, ranking, report emission and empty reports through command codes.
// Depends on tkfv_pkg.
module tkfv_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              req_type,
	input  tkfv_pkg::status_t status,
	output logic              busy,
	output tkfv_pkg::cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_COMMIT = 3'd2;
	localparam logic [2:0] ST_RANK   = 3'd3;
	localparam logic [2:0] ST_SETTLE = 3'd4;
	localparam logic [2:0] ST_EMIT   = 3'd5;
	localparam logic [2:0] ST_EMPTY  = 3'd6;

	localparam logic [tkfv_pkg::IDX_W-1:0] IDX_END = tkfv_pkg::IDX_W'(tkfv_pkg::SLOTS - 1);

	logic [2:0]                  state_q, state_d;
	logic [tkfv_pkg::IDX_W-1:0] idx_q, idx_d;

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		cmd.op  = tkfv_pkg::OP_NONE;
		cmd.idx = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				idx_d = '0;
				if (start) begin
					cmd.op = tkfv_pkg::OP_LOAD;
					if (req_type == tkfv_pkg::REQ_OBSERVE) begin
						state_d = ST_SCAN;
					end else if (status.filled_zero) begin
						state_d = ST_EMPTY;
					end else begin
						state_d = ST_RANK;
					end
				end
			end
			ST_SCAN: begin
				cmd.op = tkfv_pkg::OP_SCAN;
				if (idx_q == IDX_END) begin
					state_d = ST_COMMIT;
				end else begin
					idx_d = idx_q + tkfv_pkg::IDX_W'(1);
				end
			end
			ST_COMMIT: begin
				cmd.op  = tkfv_pkg::OP_COMMIT;
				state_d = ST_IDLE;
			end
			ST_RANK: begin
				cmd.op = tkfv_pkg::OP_RANK;
				if (status.at_last) begin
					state_d = ST_SETTLE;
					idx_d   = '0;
				end else begin
					idx_d = idx_q + tkfv_pkg::IDX_W'(1);
				end
			end
			ST_SETTLE: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.op = tkfv_pkg::OP_EMIT;
				if (status.at_last) begin
					state_d = ST_IDLE;
				end else begin
					idx_d = idx_q + tkfv_pkg::IDX_W'(1);
				end
			end
			ST_EMPTY: begin
				cmd.op  = tkfv_pkg::OP_EMPTY;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

endmodule

@@ rtl/tkfv_dp.sv @@
// Datapath of the top-k frequent value table: slot storage, scan and rank logic,
// the rank-to-slot table and the result register.
// Depends on tkfv_pkg.
module tkfv_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tkfv_pkg::cmd_t               cmd,
	output tkfv_pkg::status_t            status,
	input  tkfv_pkg::req_t               request,
	input  logic                         cfg_we,
	input  logic [tkfv_pkg::CFG_W-1:0]   cfg_wdata,
	output tkfv_pkg::res_t               result,
	output logic                         result_valid
);

	localparam int CMP_W = ((tkfv_pkg::FILL_W > tkfv_pkg::CFG_W) ?
		tkfv_pkg::FILL_W : tkfv_pkg::CFG_W) + 1;

	function automatic logic [tkfv_pkg::FILL_W-1:0] count_ones(
		input logic [tkfv_pkg::SLOTS-1:0] v);
		logic [tkfv_pkg::FILL_W-1:0] n;
		n = '0;
		for (int k = 0; k < tkfv_pkg::SLOTS; k++) begin
			n = n + tkfv_pkg::FILL_W'(v[k]);
		end
		return n;
	endfunction

	function automatic logic [tkfv_pkg::SLOT_OUT_W-1:0] out_idx(
		input logic [tkfv_pkg::IDX_W-1:0] idx);
		logic [tkfv_pkg::IDX_W+tkfv_pkg::SLOT_OUT_W-1:0] wide;
		wide = {{tkfv_pkg::SLOT_OUT_W{1'b0}}, idx};
		return wide[tkfv_pkg::SLOT_OUT_W-1:0];
	endfunction

	// Table storage; the values of entries at or above the fill count are never used.
	logic [tkfv_pkg::KEY_W-1:0]   slot_key_q  [tkfv_pkg::SLOTS];
	logic [tkfv_pkg::COUNT_W-1:0] slot_cnt_q  [tkfv_pkg::SLOTS];
	logic [tkfv_pkg::IDX_W-1:0]   rank_slot_q [tkfv_pkg::SLOTS];

	logic [tkfv_pkg::FILL_W-1:0]  filled_q;
	logic [tkfv_pkg::CFG_W-1:0]   limit_q;

	logic [tkfv_pkg::KEY_W-1:0]   req_key_q;
	logic [tkfv_pkg::COUNT_W-1:0] req_cnt_q;
	logic                         match_hit_q, cand_hit_q, cand_ins_q;
	logic [tkfv_pkg::IDX_W-1:0]   match_idx_q, cand_idx_q;

	logic [tkfv_pkg::SLOTS-1:0]   gt_s1;
	logic [tkfv_pkg::IDX_W-1:0]   gt_idx_s1;
	logic                         gt_vld_s1;

	logic [tkfv_pkg::IDX_W-1:0]   rd_idx, wr_idx, rank_pos;
	logic [tkfv_pkg::KEY_W-1:0]   rd_key;
	logic [tkfv_pkg::COUNT_W-1:0] rd_cnt;
	logic                         in_filled, below_limit, is_free, cand_now, match_now;
	logic [tkfv_pkg::SLOTS-1:0]   gt;
	logic [tkfv_pkg::FILL_W-1:0]  ones;

	// One shared read address: the scan or rank index, or during emission
	// the slot that holds the current rank.
	assign rd_idx = (cmd.op == tkfv_pkg::OP_EMIT) ? rank_slot_q[cmd.idx] : cmd.idx;
	assign rd_key = slot_key_q[rd_idx];
	assign rd_cnt = slot_cnt_q[rd_idx];

	assign in_filled   = tkfv_pkg::FILL_W'(cmd.idx) < filled_q;
	assign below_limit = CMP_W'(cmd.idx) < CMP_W'(limit_q);
	assign is_free     = tkfv_pkg::FILL_W'(cmd.idx) == filled_q;
	assign match_now   = in_filled && (rd_key == req_key_q);
	assign cand_now    = below_limit && (is_free || (in_filled && (rd_cnt < req_cnt_q)));

	// Slot j outranks the slot under test when its count is larger, or equal
	// and it sits earlier in the table.
	always_comb begin
		for (int j = 0; j < tkfv_pkg::SLOTS; j++) begin
			gt[j] = (tkfv_pkg::FILL_W'(j) < filled_q) &&
				((slot_cnt_q[j] > rd_cnt) ||
				 ((slot_cnt_q[j] == rd_cnt) && (tkfv_pkg::IDX_W'(j) < cmd.idx)));
		end
	end

	assign ones     = count_ones(gt_s1);
	assign rank_pos = ones[tkfv_pkg::IDX_W-1:0];
	assign wr_idx   = match_hit_q ? match_idx_q : cand_idx_q;

	assign status.filled_zero = (filled_q == '0);
	assign status.at_last     = tkfv_pkg::FILL_W'(cmd.idx) == (filled_q - tkfv_pkg::FILL_W'(1));

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q     <= '0;
			limit_q      <= tkfv_pkg::LIMIT_RESET;
			match_hit_q  <= 1'b0;
			cand_hit_q   <= 1'b0;
			gt_vld_s1    <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			gt_vld_s1    <= (cmd.op == tkfv_pkg::OP_RANK);
			result_valid <= (cmd.op == tkfv_pkg::OP_COMMIT) ||
				(cmd.op == tkfv_pkg::OP_EMIT) || (cmd.op == tkfv_pkg::OP_EMPTY);
			case (cmd.op)
				tkfv_pkg::OP_LOAD: begin
					match_hit_q <= 1'b0;
					cand_hit_q  <= 1'b0;
				end
				tkfv_pkg::OP_SCAN: begin
					if (!match_hit_q && match_now) begin
						match_hit_q <= 1'b1;
					end
					if (!cand_hit_q && cand_now) begin
						cand_hit_q <= 1'b1;
					end
				end
				tkfv_pkg::OP_COMMIT: begin
					if (!match_hit_q && cand_hit_q && cand_ins_q) begin
						filled_q <= filled_q + tkfv_pkg::FILL_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers and table writes.
	always_ff @(posedge clk) begin
		case (cmd.op)
			tkfv_pkg::OP_LOAD: begin
				req_key_q <= request.value_key;
				req_cnt_q <= request.est_count;
			end
			tkfv_pkg::OP_SCAN: begin
				if (!match_hit_q && match_now) begin
					match_idx_q <= cmd.idx;
				end
				if (!cand_hit_q && cand_now) begin
					cand_idx_q <= cmd.idx;
					cand_ins_q <= is_free;
				end
			end
			tkfv_pkg::OP_COMMIT: begin
				if (match_hit_q || cand_hit_q) begin
					slot_cnt_q[wr_idx] <= req_cnt_q;
				end
				if (!match_hit_q && cand_hit_q) begin
					slot_key_q[wr_idx] <= req_key_q;
				end
			end
			default: begin
			end
		endcase

		gt_s1     <= gt;
		gt_idx_s1 <= cmd.idx;
		if (gt_vld_s1) begin
			rank_slot_q[rank_pos] <= gt_idx_s1;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		case (cmd.op)
			tkfv_pkg::OP_COMMIT: begin
				result.out_key   <= req_key_q;
				result.out_count <= req_cnt_q;
				result.last      <= 1'b1;
				if (match_hit_q) begin
					result.action     <= tkfv_pkg::ACT_UPDATED;
					result.slot_index <= out_idx(match_idx_q);
				end else if (cand_hit_q) begin
					result.action     <= cand_ins_q ? tkfv_pkg::ACT_INSERTED :
						tkfv_pkg::ACT_REPLACED;
					result.slot_index <= out_idx(cand_idx_q);
				end else begin
					result.action     <= tkfv_pkg::ACT_IGNORED;
					result.slot_index <= '0;
				end
			end
			tkfv_pkg::OP_EMIT: begin
				result.action     <= tkfv_pkg::ACT_REPORT_ENTRY;
				result.slot_index <= out_idx(cmd.idx);
				result.out_key    <= rd_key;
				result.out_count  <= rd_cnt;
				result.last       <= status.at_last;
			end
			tkfv_pkg::OP_EMPTY: begin
				result.action     <= tkfv_pkg::ACT_REPORT_EMPTY;
				result.slot_index <= '0;
				result.out_key    <= '0;
				result.out_count  <= '0;
				result.last       <= 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

@@ rtl/top_k_frequent_value_table.sv @@
// Observe: a load step, a slot scan over every slot, then a commit step; the result leaves through the result register,
// and the next item can be taken while that result is on the ports.
// Report of F filled slots: a rank step per filled slot, a settle step, then F results on consecutive cycles.
// An empty report gives its one result from the empty state through the result register. Results cannot be stalled.
// Reset empties the table and sets the slot limit to 16; no clearing pass is needed.
module top_k_frequent_value_table (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  tkfv_pkg::req_t             request,
	input  logic                       cfg_we,
	input  logic [tkfv_pkg::CFG_W-1:0] cfg_wdata,
	output tkfv_pkg::res_t             result,
	output logic                       result_valid
);

	// The controller owns the sequencing and the slot or rank counter; the
	// datapath owns every stored value and reports back only two flags: an
	// empty table, and that the counter sits on the last filled slot.
	tkfv_pkg::cmd_t    cmd;
	tkfv_pkg::status_t status;

	// An item is taken at start while busy is low. The result register sits
	// between the datapath and the outputs, so the controller goes back to
	// idle while the final result of the previous item is still on the ports.
	tkfv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (request.req_type),
		.status   (status),
		.busy     (busy),
		.cmd      (cmd)
	);

	// An observe item scans every slot once, noting the first matching key
	// and the first slot that may take the key (the first free slot below the
	// limit, or an earlier one with a smaller count), then writes in a
	// commit step. A report item computes the rank of each filled slot in
	// turn, files the slot under its rank, and then reads the slots back in
	// rank order.
	tkfv_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.request      (request),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule

@@ rtl/tkfv_checker.sv @@
// Port-level assertions for the top-k frequent value table, and the bind that attaches them.
// Depends on tkfv_pkg and on top_k_frequent_value_table.
module tkfv_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input tkfv_pkg::res_t             result,
	input logic                       result_valid
);

	// An accepted item always keeps the block busy in the following cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	// Observe results are always single and final.
	a_observe_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.action == tkfv_pkg::ACT_UPDATED ||
			result.action == tkfv_pkg::ACT_INSERTED ||
			result.action == tkfv_pkg::ACT_REPLACED ||
			result.action == tkfv_pkg::ACT_IGNORED) |-> result.last)
		else $error("observe result without last");

	// An empty report carries zeros and ends the item.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.action == tkfv_pkg::ACT_REPORT_EMPTY |->
			result.slot_index == '0 && result.out_key == '0 &&
			result.out_count == '0 && result.last)
		else $error("empty report result not cleared");

	// Report entries follow in consecutive cycles with consecutive ranks.
	a_report_seq: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.action == tkfv_pkg::ACT_REPORT_ENTRY && !result.last |=>
			result_valid && result.action == tkfv_pkg::ACT_REPORT_ENTRY &&
			result.slot_index == $past(result.slot_index) + 4'd1)
		else $error("report entries out of sequence");

	// An ignored key reports slot zero.
	a_ignored_idx: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.action == tkfv_pkg::ACT_IGNORED |->
			result.slot_index == '0)
		else $error("ignored key with nonzero slot index");

endmodule

bind top_k_frequent_value_table tkfv_checker u_tkfv_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result       (result),
	.result_valid (result_valid)
);
